@@ design/sbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpf_pkg: shared types and helpers for the boundary penalty force block
// Holds the lane format, the operand and opcode encodings, the state type
// and the micro-program that drives the shared multiply/add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpf_pkg;

  localparam int LANE_BITS  = 21;
  localparam int INDEX_BITS = 20;
  localparam int VEC_BITS   = 3 * LANE_BITS;
  localparam int CFG_BITS   = 32;
  localparam int SUM_BITS   = 40;
  localparam int PC_BITS    = 7;
  localparam int TMP_DEPTH  = 32;
  localparam int TMP_ABITS  = $clog2(TMP_DEPTH);
  localparam logic [PC_BITS-1:0] PROG_LEN = PC_BITS'(75);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SCALE    = 3'd0,
    REG_INV      = 3'd1,
    REG_STIFF    = 3'd2,
    REG_DAMP     = 3'd3,
    REG_FRICTION = 3'd4,
    REG_MASS     = 3'd5
  } reg_idx_t;

  // Operand codes. Codes with the top bit set live in the scratch memory,
  // and their low bits are the memory address.
  typedef enum logic [5:0] {
    S_ZERO = 6'd0,
    S_N0 = 6'd1, S_N1 = 6'd2, S_N2 = 6'd3,
    S_R0 = 6'd4, S_R1 = 6'd5, S_R2 = 6'd6,
    S_VF0 = 6'd7, S_VF1 = 6'd8, S_VF2 = 6'd9,
    S_VL0 = 6'd10, S_VL1 = 6'd11, S_VL2 = 6'd12,
    S_VA0 = 6'd13, S_VA1 = 6'd14, S_VA2 = 6'd15,
    S_LF0 = 6'd16, S_LF1 = 6'd17, S_LF2 = 6'd18,
    S_AF0 = 6'd19, S_AF1 = 6'd20, S_AF2 = 6'd21,
    S_NDIST = 6'd22, S_SCALE = 6'd23, S_INV = 6'd24, S_STIFF = 6'd25,
    S_DAMP = 6'd26, S_FRIC = 6'd27, S_MASS = 6'd28,
    S_P = 6'd32, S_Q = 6'd33,
    S_C0 = 6'd34, S_C1 = 6'd35, S_C2 = 6'd36,
    S_VB0 = 6'd37, S_VB1 = 6'd38, S_VB2 = 6'd39,
    S_REL0 = 6'd40, S_REL1 = 6'd41, S_REL2 = 6'd42,
    S_RN = 6'd43, S_DEPTH = 6'd44, S_FM = 6'd45, S_ACC = 6'd46,
    S_FORCE0 = 6'd47, S_FORCE1 = 6'd48, S_FORCE2 = 6'd49,
    S_F0 = 6'd50, S_F1 = 6'd51, S_F2 = 6'd52,
    S_T0 = 6'd53, S_T1 = 6'd54, S_T2 = 6'd55
  } src_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_ACC = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    C_ALL  = 2'd0,
    C_DYN  = 2'd1,
    C_NDYN = 2'd2,
    C_FRIC = 2'd3
  } cond_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FETCH = 3'd1,
    ST_EXEC  = 3'd2,
    ST_WRITE = 3'd3,
    ST_DONE  = 3'd4
  } state_t;

  typedef struct packed {
    op_kind_t   kind;
    cond_t      cond;
    src_t       a;
    src_t       b;
    src_t       d;
    logic [2:0] sel;
  } op_t;

  function automatic op_t mk(op_kind_t k, cond_t c, src_t a, src_t b, src_t d);
    op_t o;
    o = '{kind: k, cond: c, a: a, b: b, d: d, sel: 3'd0};
    return o;
  endfunction

  function automatic op_t mk_acc(cond_t c, src_t a, logic [2:0] sel);
    op_t o;
    o = '{kind: OP_ACC, cond: c, a: a, b: S_ZERO, d: S_ZERO, sel: sel};
    return o;
  endfunction

  // Lane k of a packed vector as a 33-bit Q16.16 scalar.
  function automatic logic signed [32:0] lane_q(logic [VEC_BITS-1:0] v, int k);
    logic [LANE_BITS-1:0] l;
    l = v[k*LANE_BITS +: LANE_BITS];
    return {{(29-LANE_BITS){l[LANE_BITS-1]}}, l, 4'b0000};
  endfunction

  // Q16.16 value to a saturated lane, truncating toward zero.
  function automatic logic [LANE_BITS-1:0] lane_out(logic signed [SUM_BITS-1:0] v);
    logic [SUM_BITS-1:0] mg;
    logic [SUM_BITS-5:0] m;
    logic [LANE_BITS-1:0] r;
    mg = v[SUM_BITS-1] ? (~v + 1'b1) : v;
    m  = mg[SUM_BITS-1:4];
    if (v[SUM_BITS-1]) begin
      if (m >= (SUM_BITS-4)'(1 << (LANE_BITS-1))) r = {1'b1, {(LANE_BITS-1){1'b0}}};
      else r = LANE_BITS'(~m + 1'b1);
    end else begin
      if (m >= (SUM_BITS-4)'(1 << (LANE_BITS-1))) r = {1'b0, {(LANE_BITS-1){1'b1}}};
      else r = LANE_BITS'(m);
    end
    return r;
  endfunction

  // Micro-program of the contact force computation.
  function automatic op_t ucode(logic [PC_BITS-1:0] pc);
    op_t o;
    o = mk(OP_ADD, C_ALL, S_ZERO, S_ZERO, S_P);
    case (pc)
      // Angular velocity cross hit offset.
      7'd0:  o = mk(OP_MUL, C_DYN, S_VA1, S_R2, S_P);
      7'd1:  o = mk(OP_MUL, C_DYN, S_VA2, S_R1, S_Q);
      7'd2:  o = mk(OP_SUB, C_DYN, S_P, S_Q, S_C0);
      7'd3:  o = mk(OP_MUL, C_DYN, S_VA2, S_R0, S_P);
      7'd4:  o = mk(OP_MUL, C_DYN, S_VA0, S_R2, S_Q);
      7'd5:  o = mk(OP_SUB, C_DYN, S_P, S_Q, S_C1);
      7'd6:  o = mk(OP_MUL, C_DYN, S_VA0, S_R1, S_P);
      7'd7:  o = mk(OP_MUL, C_DYN, S_VA1, S_R0, S_Q);
      7'd8:  o = mk(OP_SUB, C_DYN, S_P, S_Q, S_C2);
      // Body point velocity in fluid units.
      7'd9:  o = mk(OP_ADD, C_DYN, S_VL0, S_C0, S_P);
      7'd10: o = mk(OP_MUL, C_DYN, S_P, S_SCALE, S_VB0);
      7'd11: o = mk(OP_ADD, C_DYN, S_VL1, S_C1, S_P);
      7'd12: o = mk(OP_MUL, C_DYN, S_P, S_SCALE, S_VB1);
      7'd13: o = mk(OP_ADD, C_DYN, S_VL2, S_C2, S_P);
      7'd14: o = mk(OP_MUL, C_DYN, S_P, S_SCALE, S_VB2);
      7'd15: o = mk(OP_ADD, C_NDYN, S_ZERO, S_ZERO, S_VB0);
      7'd16: o = mk(OP_ADD, C_NDYN, S_ZERO, S_ZERO, S_VB1);
      7'd17: o = mk(OP_ADD, C_NDYN, S_ZERO, S_ZERO, S_VB2);
      // Relative velocity and its normal part.
      7'd18: o = mk(OP_SUB, C_ALL, S_VF0, S_VB0, S_REL0);
      7'd19: o = mk(OP_SUB, C_ALL, S_VF1, S_VB1, S_REL1);
      7'd20: o = mk(OP_SUB, C_ALL, S_VF2, S_VB2, S_REL2);
      7'd21: o = mk(OP_MUL, C_ALL, S_N0, S_REL0, S_P);
      7'd22: o = mk(OP_MUL, C_ALL, S_N1, S_REL1, S_Q);
      7'd23: o = mk(OP_ADD, C_ALL, S_P, S_Q, S_P);
      7'd24: o = mk(OP_MUL, C_ALL, S_N2, S_REL2, S_Q);
      7'd25: o = mk(OP_ADD, C_ALL, S_P, S_Q, S_RN);
      // Spring-damper magnitude.
      7'd26: o = mk(OP_MUL, C_ALL, S_NDIST, S_SCALE, S_DEPTH);
      7'd27: o = mk(OP_MUL, C_ALL, S_STIFF, S_DEPTH, S_P);
      7'd28: o = mk(OP_MUL, C_ALL, S_DAMP, S_RN, S_Q);
      7'd29: o = mk(OP_SUB, C_ALL, S_P, S_Q, S_FM);
      // Per-lane normal force, friction and mass.
      7'd30: o = mk(OP_MUL, C_ALL, S_N0, S_FM, S_ACC);
      7'd31: o = mk(OP_MUL, C_FRIC, S_N0, S_RN, S_P);
      7'd32: o = mk(OP_SUB, C_FRIC, S_REL0, S_P, S_P);
      7'd33: o = mk(OP_MUL, C_FRIC, S_P, S_FRIC, S_Q);
      7'd34: o = mk(OP_SUB, C_FRIC, S_ACC, S_Q, S_ACC);
      7'd35: o = mk(OP_MUL, C_ALL, S_ACC, S_MASS, S_FORCE0);
      7'd36: o = mk(OP_MUL, C_ALL, S_N1, S_FM, S_ACC);
      7'd37: o = mk(OP_MUL, C_FRIC, S_N1, S_RN, S_P);
      7'd38: o = mk(OP_SUB, C_FRIC, S_REL1, S_P, S_P);
      7'd39: o = mk(OP_MUL, C_FRIC, S_P, S_FRIC, S_Q);
      7'd40: o = mk(OP_SUB, C_FRIC, S_ACC, S_Q, S_ACC);
      7'd41: o = mk(OP_MUL, C_ALL, S_ACC, S_MASS, S_FORCE1);
      7'd42: o = mk(OP_MUL, C_ALL, S_N2, S_FM, S_ACC);
      7'd43: o = mk(OP_MUL, C_FRIC, S_N2, S_RN, S_P);
      7'd44: o = mk(OP_SUB, C_FRIC, S_REL2, S_P, S_P);
      7'd45: o = mk(OP_MUL, C_FRIC, S_P, S_FRIC, S_Q);
      7'd46: o = mk(OP_SUB, C_FRIC, S_ACC, S_Q, S_ACC);
      7'd47: o = mk(OP_MUL, C_ALL, S_ACC, S_MASS, S_FORCE2);
      // Reaction force in world units.
      7'd48: o = mk(OP_MUL, C_DYN, S_FORCE0, S_INV, S_P);
      7'd49: o = mk(OP_SUB, C_DYN, S_ZERO, S_P, S_P);
      7'd50: o = mk(OP_MUL, C_DYN, S_P, S_LF0, S_F0);
      7'd51: o = mk(OP_MUL, C_DYN, S_FORCE1, S_INV, S_P);
      7'd52: o = mk(OP_SUB, C_DYN, S_ZERO, S_P, S_P);
      7'd53: o = mk(OP_MUL, C_DYN, S_P, S_LF1, S_F1);
      7'd54: o = mk(OP_MUL, C_DYN, S_FORCE2, S_INV, S_P);
      7'd55: o = mk(OP_SUB, C_DYN, S_ZERO, S_P, S_P);
      7'd56: o = mk(OP_MUL, C_DYN, S_P, S_LF2, S_F2);
      // Torque: hit offset cross reaction force.
      7'd57: o = mk(OP_MUL, C_DYN, S_R1, S_F2, S_P);
      7'd58: o = mk(OP_MUL, C_DYN, S_R2, S_F1, S_Q);
      7'd59: o = mk(OP_SUB, C_DYN, S_P, S_Q, S_T0);
      7'd60: o = mk(OP_MUL, C_DYN, S_R2, S_F0, S_P);
      7'd61: o = mk(OP_MUL, C_DYN, S_R0, S_F2, S_Q);
      7'd62: o = mk(OP_SUB, C_DYN, S_P, S_Q, S_T1);
      7'd63: o = mk(OP_MUL, C_DYN, S_R0, S_F1, S_P);
      7'd64: o = mk(OP_MUL, C_DYN, S_R1, S_F0, S_Q);
      7'd65: o = mk(OP_SUB, C_DYN, S_P, S_Q, S_T2);
      // Group sums.
      7'd66: o = mk_acc(C_DYN, S_F0, 3'd0);
      7'd67: o = mk(OP_MUL, C_DYN, S_T0, S_AF0, S_P);
      7'd68: o = mk_acc(C_DYN, S_P, 3'd3);
      7'd69: o = mk_acc(C_DYN, S_F1, 3'd1);
      7'd70: o = mk(OP_MUL, C_DYN, S_T1, S_AF1, S_P);
      7'd71: o = mk_acc(C_DYN, S_P, 3'd4);
      7'd72: o = mk_acc(C_DYN, S_F2, 3'd2);
      7'd73: o = mk(OP_MUL, C_DYN, S_T2, S_AF2, S_P);
      7'd74: o = mk_acc(C_DYN, S_P, 3'd5);
      default: o = mk(OP_ADD, C_ALL, S_ZERO, S_ZERO, S_P);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

@@ design/sph_boundary_penalty_force.sv @@
// Each executed micro-op of the 75-step program passes through fetch, execute
// and writeback; a skipped one only through fetch. A contact that does not
// penetrate skips the program and goes straight to the done state.
// Contacts are worked one at a time; the next is taken only after the
// result is registered and the block is back in idle. rst clears control,
// configuration to its defaults and the group sums to zero.
// ----------------------------------------------------------------------------
// sph_boundary_penalty_force: spring-damper contact force for fluid particles
// One contact is worked through a micro-program on a shared multiply/add
// unit; body force and torque are summed per group and emitted at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_boundary_penalty_force (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire [2:0]                            cfg_index,
  input  wire [sbpf_pkg::CFG_BITS-1:0]         cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [sbpf_pkg::INDEX_BITS-1:0]       particle_index,
  input  wire [31:0]                           contact_distance,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         contact_normal,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         hit_offset,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         fluid_velocity,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         body_linear_velocity,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         body_angular_velocity,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         body_linear_factor,
  input  wire [sbpf_pkg::VEC_BITS-1:0]         body_angular_factor,
  input  wire                                  body_is_dynamic,
  input  wire                                  last_of_group,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [sbpf_pkg::INDEX_BITS-1:0]      out_particle_index,
  output logic [sbpf_pkg::VEC_BITS-1:0]        particle_force,
  output logic [sbpf_pkg::VEC_BITS-1:0]        body_force,
  output logic [sbpf_pkg::VEC_BITS-1:0]        body_torque,
  output logic                                 group_done
);

  import sbpf_pkg::*;

  // Configuration registers.
  logic [CFG_BITS-1:0] sim_scale, inv_scale, stiffness, damping, friction, mass;

  // Captured contact.
  logic [INDEX_BITS-1:0] pidx;
  logic signed [31:0]    cdist;
  logic [VEC_BITS-1:0]   nrm, hoff, vfl, vlin, vang, lfac, afac;
  logic                  dyn, last;

  state_t state, state_next;
  logic [PC_BITS-1:0] pc;
  op_t op_fetch, cur_op;
  logic cond_ok;

  logic [31:0] tmp_mem [TMP_DEPTH];
  logic [31:0] rd_a, rd_b;

  logic signed [32:0] opa, opb, opa_r;
  logic [65:0]        prod;
  logic               neg;
  logic signed [33:0] sum;

  logic signed [SUM_BITS-1:0] sums [6];
  logic signed [LANE_BITS-1:0] frc [3];

  logic signed [31:0] wr_val;
  logic signed [SUM_BITS-1:0] acc_val;
  logic out_free;

  // Operand selection for the shared unit.
  function automatic logic signed [32:0] operand(src_t s, logic [31:0] rd);
    logic signed [32:0] v;
    case (s)
      S_N0:    v = lane_q(nrm, 0);
      S_N1:    v = lane_q(nrm, 1);
      S_N2:    v = lane_q(nrm, 2);
      S_R0:    v = lane_q(hoff, 0);
      S_R1:    v = lane_q(hoff, 1);
      S_R2:    v = lane_q(hoff, 2);
      S_VF0:   v = lane_q(vfl, 0);
      S_VF1:   v = lane_q(vfl, 1);
      S_VF2:   v = lane_q(vfl, 2);
      S_VL0:   v = lane_q(vlin, 0);
      S_VL1:   v = lane_q(vlin, 1);
      S_VL2:   v = lane_q(vlin, 2);
      S_VA0:   v = lane_q(vang, 0);
      S_VA1:   v = lane_q(vang, 1);
      S_VA2:   v = lane_q(vang, 2);
      S_LF0:   v = lane_q(lfac, 0);
      S_LF1:   v = lane_q(lfac, 1);
      S_LF2:   v = lane_q(lfac, 2);
      S_AF0:   v = lane_q(afac, 0);
      S_AF1:   v = lane_q(afac, 1);
      S_AF2:   v = lane_q(afac, 2);
      S_NDIST: v = -{cdist[31], cdist};
      S_SCALE: v = {1'b0, sim_scale};
      S_INV:   v = {1'b0, inv_scale};
      S_STIFF: v = {1'b0, stiffness};
      S_DAMP:  v = {1'b0, damping};
      S_FRIC:  v = {1'b0, friction};
      S_MASS:  v = {1'b0, mass};
      default: v = s[5] ? {rd[31], rd} : 33'sd0;
    endcase
    return v;
  endfunction

  // Sequencer: fetch, skip or issue one micro-op at a time.
  always_comb begin
    op_fetch = ucode(pc);
    unique case (op_fetch.cond)
      C_ALL:  cond_ok = 1'b1;
      C_DYN:  cond_ok = dyn;
      C_NDYN: cond_ok = !dyn;
      C_FRIC: cond_ok = (friction != '0);
      default: cond_ok = 1'b1;
    endcase
    out_free   = !out_valid || !out_stall;
    in_stall   = (state != ST_IDLE);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = contact_distance[31] ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        if (pc == PROG_LEN) state_next = ST_DONE;
        else if (cond_ok) state_next = ST_EXEC;
      end
      ST_EXEC:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_FETCH;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Program counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (state == ST_IDLE) begin
      pc <= '0;
    end else if ((state == ST_FETCH && !cond_ok && pc != PROG_LEN) || state == ST_WRITE) begin
      pc <= pc + 1'b1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sim_scale <= 32'h0001_0000;
      inv_scale <= 32'h0001_0000;
      stiffness <= '0;
      damping   <= '0;
      friction  <= '0;
      mass      <= 32'h0001_0000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE:    sim_scale <= cfg_data;
        REG_INV:      inv_scale <= cfg_data;
        REG_STIFF:    stiffness <= cfg_data;
        REG_DAMP:     damping   <= cfg_data;
        REG_FRICTION: friction  <= cfg_data;
        REG_MASS:     mass      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      pidx  <= particle_index;
      cdist <= contact_distance;
      nrm   <= contact_normal;
      hoff  <= hit_offset;
      vfl   <= fluid_velocity;
      vlin  <= body_linear_velocity;
      vang  <= body_angular_velocity;
      lfac  <= body_linear_factor;
      afac  <= body_angular_factor;
      dyn   <= body_is_dynamic;
      last  <= last_of_group;
    end
  end

  // Scratch memory: two registered reads at fetch, one write at writeback.
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      rd_a   <= tmp_mem[op_fetch.a[TMP_ABITS-1:0]];
      rd_b   <= tmp_mem[op_fetch.b[TMP_ABITS-1:0]];
      cur_op <= op_fetch;
    end
    if (state == ST_WRITE && cur_op.kind != OP_ACC) begin
      tmp_mem[cur_op.d[TMP_ABITS-1:0]] <= wr_val;
    end
  end

  // Shared unit, first half: magnitude product and wide sum.
  always_comb begin
    opa = operand(cur_op.a, rd_a);
    opb = operand(cur_op.b, rd_b);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      prod  <= {33'd0, (opa[32] ? -opa : opa)} * {33'd0, (opb[32] ? -opb : opb)};
      neg   <= opa[32] ^ opb[32];
      sum   <= (cur_op.kind == OP_SUB) ? ({opa[32], opa} - {opb[32], opb})
                                       : ({opa[32], opa} + {opb[32], opb});
      opa_r <= opa;
    end
  end

  // Shared unit, second half: shift, sign and saturation.
  always_comb begin
    logic [49:0] ps;
    ps = prod[65:16];
    wr_val = '0;
    if (cur_op.kind == OP_MUL) begin
      if (neg) wr_val = (ps >= 50'd2147483648) ? 32'sh8000_0000 : -$signed(ps[31:0]);
      else wr_val = (ps >= 50'd2147483648) ? 32'sh7fff_ffff : $signed(ps[31:0]);
    end else begin
      if (sum > 34'sd2147483647) wr_val = 32'sh7fff_ffff;
      else if (sum < -34'sd2147483648) wr_val = 32'sh8000_0000;
      else wr_val = sum[31:0];
    end
  end

  always_comb begin
    logic signed [SUM_BITS:0] t;
    t = {sums[cur_op.sel][SUM_BITS-1], sums[cur_op.sel]}
        + {{(SUM_BITS-32){opa_r[32]}}, opa_r};
    if (t[SUM_BITS] != t[SUM_BITS-1]) begin
      acc_val = t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      acc_val = t[SUM_BITS-1:0];
    end
  end

  // Group sums and the particle force shadow.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) sums[i] <= '0;
    end else if (state == ST_WRITE && cur_op.kind == OP_ACC) begin
      sums[cur_op.sel] <= acc_val;
    end else if (state == ST_DONE && out_free && last) begin
      for (int i = 0; i < 6; i++) sums[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      for (int i = 0; i < 3; i++) frc[i] <= '0;
    end else if (state == ST_WRITE && cur_op.kind == OP_MUL) begin
      if (cur_op.d == S_FORCE0) frc[0] <= lane_out(SUM_BITS'(wr_val));
      if (cur_op.d == S_FORCE1) frc[1] <= lane_out(SUM_BITS'(wr_val));
      if (cur_op.d == S_FORCE2) frc[2] <= lane_out(SUM_BITS'(wr_val));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_particle_index <= pidx;
      particle_force     <= {frc[2], frc[1], frc[0]};
      group_done         <= last;
      if (last) begin
        body_force  <= {lane_out(sums[2]), lane_out(sums[1]), lane_out(sums[0])};
        body_torque <= {lane_out(sums[5]), lane_out(sums[4]), lane_out(sums[3])};
      end else begin
        body_force  <= '0;
        body_torque <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC || state == ST_WRITE) |-> in_stall)
    else $error("input accepted while the shared unit is busy");
  a_dry_contact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && !contact_distance[31]) |=> (state == ST_DONE))
    else $error("non-penetrating contact entered the program");
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (pc <= PROG_LEN))
    else $error("program counter ran past the program");
  a_group_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free && last) |=> (sums[0] == '0 && sums[5] == '0))
    else $error("group sums not cleared after closing a group");
`endif

endmodule

`default_nettype wire
